/* hw/rtl/obrb_pkg.sv */
// obrb_pkg: shared constants, payload structs and control structs for the
// overwriting byte ring buffer. No dependencies.
`default_nettype none

package obrb_pkg;

  // ring depth; must be a power of two so positions are the low count bits
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAX_READ = 64;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(MAX_READ + 1);
  localparam int unsigned AVAIL_W = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_in;
    logic       msg_end;
    logic [6:0] max_bytes;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic               byte_valid;
    logic               last;
    logic               status;
    logic [31:0]        lost_count;
    logic [AVAIL_W-1:0] available;
    logic               data_ready;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;
    logic issue;
    logic load_byte;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stream_read;
    logic out_free;
    logic pending;
    logic fetch_left_nz;
    logic emit_last;
  } dp_status_t;

  // unread count as reported: saturates at DEPTH+1 for an overrun
  function automatic logic [AVAIL_W-1:0] sat_avail(input logic [31:0] u);
    logic [AVAIL_W-1:0] r;
    if (u > 32'(DEPTH)) begin
      r = AVAIL_W'(DEPTH + 1);
    end else begin
      r = u[AVAIL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/obrb_ctrl.sv */
// obrb_ctrl: state machine for the ring buffer; sequences item acceptance
// and byte streaming of reads. Depends on obrb_pkg.
`default_nettype none

module obrb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  obrb_pkg::dp_status_t st,
  output obrb_pkg::ctrl_cmd_t  cmd
);
  import obrb_pkg::*;

  typedef enum logic {
    IDLE,
    STREAM
  } state_t;

  state_t state;
  logic   take;
  logic   load;

  assign in_ready = (state == IDLE) && st.out_free;
  assign take     = in_valid && in_ready;
  assign load     = (state == STREAM) && st.pending && st.out_free;

  always_comb begin
    cmd.take_item = take;
    cmd.load_byte = load;
    // fetch ahead only when the fetched byte register is empty or draining
    cmd.issue     = (state == STREAM) && st.fetch_left_nz && (!st.pending || load);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (take && st.stream_read) state <= STREAM;
        end
        STREAM: begin
          if (load && st.emit_last) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/obrb_datapath.sv */
// obrb_datapath: ring memory, write count, read tail, read counters and the
// output register. Driven by obrb_ctrl commands. Depends on obrb_pkg.
`default_nettype none

module obrb_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  obrb_pkg::in_item_t   in_data,
  input  obrb_pkg::ctrl_cmd_t  cmd,
  output obrb_pkg::dp_status_t st,
  output obrb_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  wire                  out_ready
);
  import obrb_pkg::*;

  logic [7:0]         ring [DEPTH];
  logic [7:0]         mem_q;
  logic               pending;
  logic [AW-1:0]      rd_addr;
  logic [CNT_W-1:0]   fetch_left;
  logic [CNT_W-1:0]   emit_left;
  logic [AVAIL_W-1:0] avail_hold;
  logic [31:0]        write_count;
  logic [31:0]        read_tail;

  logic [31:0]        unread;
  logic [31:0]        unread_wr;
  logic               overrun;
  logic [CNT_W-1:0]   max_clamp;
  logic [CNT_W-1:0]   n;
  logic               is_write;
  logic               single_load;

  assign is_write  = (in_data.cmd == CMD_WRITE);
  assign unread    = write_count - read_tail;
  assign unread_wr = write_count + 32'd1 - read_tail;
  assign overrun   = unread > 32'(DEPTH);
  assign max_clamp = (in_data.max_bytes > 7'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                        : CNT_W'(in_data.max_bytes);
  assign n         = (unread < 32'(max_clamp)) ? unread[CNT_W-1:0] : max_clamp;

  always_comb begin
    st.stream_read   = !is_write && (in_data.max_bytes != 7'd0) && !overrun
                       && (unread != 32'd0);
    st.out_free      = !out_valid || out_ready;
    st.pending       = pending;
    st.fetch_left_nz = (fetch_left != '0);
    st.emit_last     = (emit_left == CNT_W'(1));
  end

  assign single_load = cmd.take_item && !st.stream_read;

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_item && is_write) ring[write_count[AW-1:0]] <= in_data.byte_in;
    if (cmd.issue) mem_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_tail   <= '0;
      pending     <= 1'b0;
      fetch_left  <= '0;
      emit_left   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        if (is_write) begin
          write_count <= write_count + 32'd1;
        end else if (in_data.max_bytes != 7'd0) begin
          if (overrun) begin
            read_tail <= write_count;
          end else if (unread != 32'd0) begin
            read_tail  <= read_tail + 32'(n);
            fetch_left <= n;
            emit_left  <= n;
          end
        end
      end
      if (cmd.issue) fetch_left <= fetch_left - CNT_W'(1);
      if (cmd.load_byte) emit_left <= emit_left - CNT_W'(1);
      if (cmd.issue) begin
        pending <= 1'b1;
      end else if (cmd.load_byte) begin
        pending <= 1'b0;
      end
      if (single_load || cmd.load_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      rd_addr    <= read_tail[AW-1:0];
      avail_hold <= sat_avail(unread - 32'(n));
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + AW'(1);
    end
    if (single_load) begin
      out_data.byte_out   <= 8'd0;
      out_data.byte_valid <= 1'b0;
      out_data.last       <= 1'b1;
      if (is_write) begin
        out_data.status     <= 1'b0;
        out_data.lost_count <= 32'd0;
        out_data.available  <= sat_avail(unread_wr);
        out_data.data_ready <= in_data.msg_end;
      end else if (in_data.max_bytes != 7'd0 && overrun) begin
        out_data.status     <= 1'b1;
        out_data.lost_count <= unread;
        out_data.available  <= '0;
        out_data.data_ready <= 1'b0;
      end else begin
        out_data.status     <= 1'b0;
        out_data.lost_count <= 32'd0;
        out_data.available  <= sat_avail(unread);
        out_data.data_ready <= 1'b0;
      end
    end else if (cmd.load_byte) begin
      out_data.byte_out   <= mem_q;
      out_data.byte_valid <= 1'b1;
      out_data.last       <= (emit_left == CNT_W'(1));
      out_data.status     <= 1'b0;
      out_data.lost_count <= 32'd0;
      out_data.available  <= avail_hold;
      out_data.data_ready <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/overwriting_byte_ring_buffer.sv */
// overwriting_byte_ring_buffer: top level joining obrb_ctrl and
// obrb_datapath. Depends on obrb_pkg, obrb_ctrl, obrb_datapath.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries write and
// read commands; one output channel (out_valid/out_ready/out_data) carries
// results. A write stores one byte and always gives one result; the writer
// is never blocked by a slow reader, old bytes are overwritten.
// A read gives one result (empty, or overrun with the lost count) or a
// burst of up to 64 byte results, the last one flagged.
// Timing: a single result is registered in the cycle after its item is
// accepted; a read burst is fetched through the registered ring read port,
// then streamed one byte per cycle while the receiver keeps up.
// Throughput: writes and single-result reads go one per cycle when the
// receiver keeps up; a burst blocks new items until its last byte is loaded.
// Stalls: the output register holds its result while out_ready is low and
// in_ready drops until the slot frees. Reset clears both counters; the
// ring contents are not cleared and need no clearing pass.
`default_nettype none

module overwriting_byte_ring_buffer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  obrb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output obrb_pkg::out_item_t out_data
);
  import obrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  obrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  obrb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // a write always produces its result in the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.cmd == CMD_WRITE) |=> out_valid)
    else $error("write item gave no result");

  // byte results never carry overrun or message flags
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.byte_valid) |-> (!out_data.status && !out_data.data_ready))
    else $error("byte result carries status or data_ready");

  // no new item is taken while bytes are still being fetched
  a_no_take_streaming: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !in_ready)
    else $error("input accepted during read burst");

  // fetched byte is only dropped by loading it into the output register
  a_pending_hold: assert property (@(posedge clk) disable iff (rst)
    (st.pending && !cmd.load_byte) |=> st.pending)
    else $error("fetched byte lost");

endmodule

`default_nettype wire

/* dv/overwriting_byte_ring_buffer_tb.sv */
// overwriting_byte_ring_buffer_tb: self-checking bench for the overwriting byte ring.
// A queue-fed driver, a stalling receiver, a mirror of the ring that predicts each
// result, and an in-order checker. Depends on obrb_pkg and overwriting_byte_ring_buffer.
module overwriting_byte_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obrb_pkg::*;

  localparam int unsigned LONG_IDLE_MAX = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned ITEM_BOUND    = 4000;
  localparam int unsigned CYCLE_LIMIT   =
    3 * (ITEM_BOUND * (MAX_READ * (LONG_IDLE_MAX + 1) + LONG_IDLE_MAX + 2) + 2 * LONG_HOLD);
  localparam int unsigned SHOW_LIMIT    = 10;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // mirror of the ring and its two counters
  logic [7:0]  ring_mirror [DEPTH];
  logic [31:0] wr_count_m = '0;
  logic [31:0] rd_tail_m  = '0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int   items_queued  = 0;
  int   items_taken   = 0;
  int   results_seen  = 0;
  int   error_count   = 0;
  int   cycle_count   = 0;
  int   n_writes      = 0;
  int   n_reads       = 0;
  int   n_bytes_read  = 0;
  int   n_overruns    = 0;
  int   n_empty       = 0;
  logic in_fire       = 1'b0;
  logic long_hold_req = 1'b0;
  int   tx_gap_left   = 0;
  int   tx_calm       = 0;
  int   rx_stall_left = 0;
  int   rx_calm       = 0;
  int   rx_hold_left  = 0;

  out_item_t want_q;
  string     bad_fields;

  overwriting_byte_ring_buffer DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // mostly no idle, some short gaps, a few long ones, and now and then a calm stretch
  function automatic int draw_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 58) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, LONG_IDLE_MAX);
  endfunction

  task automatic predict_item(input in_item_t it);
    out_item_t          r;
    out_item_t          burst[$];
    logic [31:0]        unread;
    logic [31:0]        fill;
    logic [AVAIL_W-1:0] avail_now;
    int                 take;
    r = '0;
    r.last = 1'b1;
    if (it.cmd == CMD_WRITE) begin
      ring_mirror[wr_count_m % DEPTH] = it.byte_in;
      wr_count_m = wr_count_m + 1;
      r.data_ready = it.msg_end;
      burst.push_back(r);
      n_writes++;
    end else begin
      unread = wr_count_m - rd_tail_m;
      n_reads++;
      if (it.max_bytes == 0 || unread == 0) begin
        burst.push_back(r);
        n_empty++;
      end else if (unread > DEPTH) begin
        // writer lapped the reader: report the loss and resync the tail
        r.status = 1'b1;
        r.lost_count = unread;
        rd_tail_m = wr_count_m;
        burst.push_back(r);
        n_overruns++;
      end else begin
        take = (unread < it.max_bytes) ? int'(unread) : int'(it.max_bytes);
        if (take > MAX_READ) take = MAX_READ;
        for (int i = 0; i < take; i++) begin
          r = '0;
          r.byte_out = ring_mirror[(rd_tail_m + i) % DEPTH];
          r.byte_valid = 1'b1;
          r.last = (i == take - 1);
          burst.push_back(r);
        end
        rd_tail_m = rd_tail_m + take;
        n_bytes_read += take;
      end
    end
    fill = wr_count_m - rd_tail_m;
    avail_now = (fill > DEPTH) ? AVAIL_W'(DEPTH + 1) : fill[AVAIL_W-1:0];
    foreach (burst[k]) begin
      burst[k].available = avail_now;
      expected_results.push_back(burst[k]);
    end
  endtask

  function automatic string fmt_result(input out_item_t x);
    return $sformatf("byte=%02h valid=%0b last=%0b status=%0b lost=%0d avail=%0d ready=%0b",
                     x.byte_out, x.byte_valid, x.last, x.status, x.lost_count,
                     x.available, x.data_ready);
  endfunction

  function automatic string diff_fields(input out_item_t want, input out_item_t got);
    string s;
    s = "";
    if (got.byte_out   !== want.byte_out)   s = {s, " byte_out"};
    if (got.byte_valid !== want.byte_valid) s = {s, " byte_valid"};
    if (got.last       !== want.last)       s = {s, " last"};
    if (got.status     !== want.status)     s = {s, " status"};
    if (got.lost_count !== want.lost_count) s = {s, " lost_count"};
    if (got.available  !== want.available)  s = {s, " available"};
    if (got.data_ready !== want.data_ready) s = {s, " data_ready"};
    return s;
  endfunction

  task automatic push_write(input logic [7:0] b, input logic last_byte);
    in_item_t it;
    it.cmd       = CMD_WRITE;
    it.byte_in   = b;
    it.msg_end   = last_byte;
    it.max_bytes = 7'($urandom);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_read(input logic [6:0] max_len);
    in_item_t it;
    it.cmd       = CMD_READ;
    it.byte_in   = 8'($urandom);
    it.msg_end   = 1'($urandom);
    it.max_bytes = max_len;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_all_done();
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  // messages with msg_end on their last byte, reads of mixed lengths, some stray items
  task automatic queue_traffic(input int target);
    int made;
    int len;
    int pick;
    int r;
    logic [6:0] max_len;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) push_write(8'($urandom), k == len - 1);
        made += len;
      end else if (pick < 85) begin
        r = $urandom_range(0, 99);
        if (r < 10) max_len = 7'd0;
        else if (r < 75) max_len = 7'($urandom_range(1, 12));
        else if (r < 90) max_len = 7'($urandom_range(13, 64));
        else max_len = 7'($urandom_range(65, 127));
        push_read(max_len);
        made++;
      end else begin
        if ($urandom_range(0, 1) == 1) push_write(8'($urandom), 1'($urandom));
        else push_read(7'($urandom));
        made++;
      end
    end
  endtask

  // sender: holds an item until taken, then idles as drawn
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        tx_gap_left = draw_idle(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_stall_left = draw_idle(rx_calm);
    end
  end

  // monitor: check the result taken at this edge, then predict for the item taken
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("overwriting_byte_ring_buffer_tb: errors");
      $finish;
    end else if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= SHOW_LIMIT)
            $display("unexpected result: %s", fmt_result(out_data));
        end else begin
          want_q = expected_results.pop_front();
          bad_fields = diff_fields(want_q, out_data);
          if (bad_fields != "") begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
              $display("result %0d wrong in%s\n  expected %s\n  got      %s",
                       results_seen, bad_fields, fmt_result(want_q), fmt_result(out_data));
          end
        end
        results_seen++;
      end
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        predict_item(in_data);
        items_taken++;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: empty ring, zero request, byte extremes, oversized requests
    push_read(7'd5);
    push_read(7'd0);
    push_write(8'h00, 1'b0);
    push_write(8'hFF, 1'b1);
    push_write(8'hA5, 1'b0);
    push_write(8'h5A, 1'b1);
    push_read(7'd0);
    push_read(7'd1);
    push_read(7'd127);
    push_read(7'd64);
    push_write(8'h80, 1'b1);
    push_write(8'h7F, 1'b0);
    push_write(8'h01, 1'b1);
    push_read(7'd65);
    push_read(7'd64);
    wait_all_done();

    // receiver holds off while writes keep coming, so the input stalls
    @(posedge clk);
    long_hold_req = 1'b1;
    repeat (40) push_write(8'($urandom), $urandom_range(0, 7) == 0);
    wait_all_done();
    push_read(7'd0);
    push_read(7'd127);
    push_read(7'd64);
    wait_all_done();

    queue_traffic(150);
    // sender pauses until everything is back
    wait_all_done();
    queue_traffic(150);
    wait_all_done();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("ran %0d writes and %0d reads: %0d bytes read back, %0d overruns, %0d empty",
             n_writes, n_reads, n_bytes_read, n_overruns, n_empty);
    $display("checked %0d results, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("overwriting_byte_ring_buffer_tb: clean");
    end else begin
      $display("overwriting_byte_ring_buffer_tb: errors");
    end
    $finish;
  end

endmodule
